### sv/assert_macros.svh
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define LSX_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lsx assertion failed");

// antecedent implies consequent in the following cycle
`define LSX_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lsx assertion failed");

`endif

### sv/lsx_pkg.sv
// Types, codes and header check function for the BMP LSB extractor
package lsx_pkg;

  localparam int unsigned HEADER_BYTES = 54;
  localparam int unsigned LENGTH_BYTES = 4;

  localparam logic [31:0] LEN_OVERHEAD = 32'(HEADER_BYTES + LENGTH_BYTES);

  localparam logic [7:0] SIG_B    = 8'h42;
  localparam logic [7:0] SIG_M    = 8'h4D;
  localparam logic [7:0] LSBE_TAG = 8'hFE;
  localparam logic [7:0] INFO_SZ  = 8'd40;
  localparam logic [7:0] BPP_24   = 8'd24;

  localparam logic [1:0] MODE_LSB1 = 2'd0;
  localparam logic [1:0] MODE_LSB4 = 2'd1;
  localparam logic [1:0] MODE_LSBE = 2'd2;
  localparam logic [1:0] MODE_LSB8 = 2'd3;

  localparam logic [1:0] REG_LSB_MODE  = 2'd0;
  localparam logic [1:0] REG_PLAIN     = 2'd1;
  localparam logic [1:0] REG_FILE_SIZE = 2'd2;

  localparam logic [2:0] ST_BYTE      = 3'd0;
  localparam logic [2:0] ST_HDR_OK    = 3'd1;
  localparam logic [2:0] ST_HDR_BAD   = 3'd2;
  localparam logic [2:0] ST_TOO_LARGE = 3'd3;
  localparam logic [2:0] ST_LEN_ZERO  = 3'd4;

  localparam logic [4:0] FLT_SIG   = 5'b00001;
  localparam logic [4:0] FLT_OFFS  = 5'b00010;
  localparam logic [4:0] FLT_INFO  = 5'b00100;
  localparam logic [4:0] FLT_DEPTH = 5'b01000;
  localparam logic [4:0] FLT_COMPR = 5'b10000;

  typedef struct packed {
    logic [1:0]  lsb_mode;
    logic        plain_payload;
    logic [31:0] len_limit;
  } cfg_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       is_extension;
    logic       last;
    logic [2:0] status;
    logic [4:0] header_faults;
  } res_t;

  function automatic logic [4:0] hdr_fault(input logic [5:0] pos, input logic [7:0] b);
    logic [4:0] bad;
    bad = '0;
    case (pos)
      6'd0: if (b != SIG_B) bad = FLT_SIG;
      6'd1: if (b != SIG_M) bad = FLT_SIG;
      6'd10: if (b != 8'(HEADER_BYTES)) bad = FLT_OFFS;
      6'd11, 6'd12, 6'd13: if (b != 8'd0) bad = FLT_OFFS;
      6'd14: if (b != INFO_SZ) bad = FLT_INFO;
      6'd15, 6'd16, 6'd17: if (b != 8'd0) bad = FLT_INFO;
      6'd28: if (b != BPP_24) bad = FLT_DEPTH;
      6'd29: if (b != 8'd0) bad = FLT_DEPTH;
      6'd30, 6'd31, 6'd32, 6'd33: if (b != 8'd0) bad = FLT_COMPR;
      default: bad = '0;
    endcase
    return bad;
  endfunction

endpackage

### sv/lsx_in_stage.sv
// Input register stage for carrier byte transactions
module lsx_in_stage
  import lsx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_carrier_byte,
  input  logic       in_start_of_file,
  input  logic       go,
  output logic       s1_valid,
  output logic [7:0] s1_byte,
  output logic       s1_sof
);

  logic       valid_r;
  logic [7:0] byte_r;
  logic       sof_r;

  assign in_ready = !valid_r || go;
  assign s1_valid = valid_r;
  assign s1_byte  = byte_r;
  assign s1_sof   = sof_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_carrier_byte;
      sof_r  <= in_start_of_file;
    end
  end

endmodule

### sv/lsx_extract.sv
// Header check, bit gathering and length/payload/extension sequencing
module lsx_extract
  import lsx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       s1_valid,
  input  logic [7:0] s1_byte,
  input  logic       s1_sof,
  input  logic       out_space,
  output logic       go,
  output logic       res_valid,
  output res_t       res
);

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_LENGTH  = 3'd1;
  localparam logic [2:0] PH_PAYLOAD = 3'd2;
  localparam logic [2:0] PH_EXT     = 3'd3;
  localparam logic [2:0] PH_IDLE    = 3'd4;

  logic [2:0]  phase_r, phase_nxt, ph;
  logic [5:0]  hpos_r, hpos_nxt, hpos;
  logic [4:0]  flt_r, flt_nxt, flt;
  logic [2:0]  bitpos_r, bitpos_nxt, bitpos;
  logic [7:0]  asm_r, asm_nxt, asm_c;
  logic [2:0]  lcnt_r, lcnt_nxt, lcnt;
  logic [31:0] len_r, len_nxt, len;
  logic [31:0] emit_r, emit_nxt, emit;

  logic [3:0]  k;
  logic [3:0]  bsum;
  logic        take;
  logic        full;
  logic [7:0]  shifted;
  logic [31:0] new_len;
  logic [32:0] emit_inc;
  logic [4:0]  flt_new;

  always_comb begin
    ph     = s1_sof ? PH_HEADER : phase_r;
    hpos   = s1_sof ? '0 : hpos_r;
    flt    = s1_sof ? '0 : flt_r;
    bitpos = s1_sof ? '0 : bitpos_r;
    asm_c  = s1_sof ? '0 : asm_r;
    lcnt   = s1_sof ? '0 : lcnt_r;
    len    = s1_sof ? '0 : len_r;
    emit   = s1_sof ? '0 : emit_r;

    phase_nxt  = ph;
    hpos_nxt   = hpos;
    flt_nxt    = flt;
    bitpos_nxt = bitpos;
    asm_nxt    = asm_c;
    lcnt_nxt   = lcnt;
    len_nxt    = len;
    emit_nxt   = emit;
    res_valid  = 1'b0;
    res        = '0;

    case (cfg.lsb_mode)
      MODE_LSB4: begin
        k       = 4'd4;
        shifted = {asm_c[3:0], s1_byte[3:0]};
      end
      MODE_LSB8: begin
        k       = 4'd8;
        shifted = s1_byte;
      end
      default: begin
        k       = 4'd1;
        shifted = {asm_c[6:0], s1_byte[0]};
      end
    endcase
    take     = !(cfg.lsb_mode == MODE_LSBE && (s1_byte & LSBE_TAG) != LSBE_TAG);
    bsum     = {1'b0, bitpos} + k;
    full     = bsum[3];
    new_len  = {len[23:0], shifted};
    emit_inc = {1'b0, emit} + 33'd1;
    flt_new  = flt | hdr_fault(hpos, s1_byte);

    case (ph)
      PH_HEADER: begin
        flt_nxt  = flt_new;
        hpos_nxt = hpos + 6'd1;
        if (hpos == 6'(HEADER_BYTES - 1)) begin
          res_valid = 1'b1;
          if (flt_new != '0) begin
            phase_nxt         = PH_IDLE;
            res.last          = 1'b1;
            res.status        = ST_HDR_BAD;
            res.header_faults = flt_new;
          end else begin
            phase_nxt  = PH_LENGTH;
            res.status = ST_HDR_OK;
          end
        end
      end
      PH_LENGTH, PH_PAYLOAD, PH_EXT: begin
        if (take) begin
          if (!full) begin
            bitpos_nxt = bsum[2:0];
            asm_nxt    = shifted;
          end else begin
            bitpos_nxt = '0;
            asm_nxt    = '0;
            if (ph == PH_LENGTH) begin
              len_nxt  = new_len;
              lcnt_nxt = lcnt + 3'd1;
              if (lcnt == 3'(LENGTH_BYTES - 1)) begin
                if (new_len >= cfg.len_limit) begin
                  phase_nxt  = PH_IDLE;
                  res_valid  = 1'b1;
                  res.last   = 1'b1;
                  res.status = ST_TOO_LARGE;
                end else if (new_len == '0) begin
                  phase_nxt  = PH_IDLE;
                  res_valid  = 1'b1;
                  res.last   = 1'b1;
                  res.status = ST_LEN_ZERO;
                end else begin
                  phase_nxt = PH_PAYLOAD;
                end
              end
            end else if (ph == PH_PAYLOAD) begin
              emit_nxt         = emit_inc[31:0];
              res_valid        = 1'b1;
              res.payload_byte = shifted;
              if (emit_inc >= {1'b0, len}) begin
                if (cfg.plain_payload) begin
                  phase_nxt = PH_EXT;
                end else begin
                  phase_nxt = PH_IDLE;
                  res.last  = 1'b1;
                end
              end
            end else begin
              res_valid        = 1'b1;
              res.is_extension = 1'b1;
              res.payload_byte = shifted;
              if (shifted == 8'd0) begin
                phase_nxt = PH_IDLE;
                res.last  = 1'b1;
              end
            end
          end
        end
      end
      default: begin
        phase_nxt = ph;
      end
    endcase

    go = s1_valid && (!res_valid || out_space);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      hpos_r   <= '0;
      flt_r    <= '0;
      bitpos_r <= '0;
      asm_r    <= '0;
      lcnt_r   <= '0;
      len_r    <= '0;
      emit_r   <= '0;
    end else if (go) begin
      phase_r  <= phase_nxt;
      hpos_r   <= hpos_nxt;
      flt_r    <= flt_nxt;
      bitpos_r <= bitpos_nxt;
      asm_r    <= asm_nxt;
      lcnt_r   <= lcnt_nxt;
      len_r    <= len_nxt;
      emit_r   <= emit_nxt;
    end
  end

endmodule

### sv/lsx_out_stage.sv
// Result register driving the output channel
module lsx_out_stage
  import lsx_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  res_t res,
  input  logic out_ready,
  output logic out_space,
  output logic out_valid,
  output res_t out_res
);

  logic valid_r;
  res_t res_r;

  assign out_space = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_space) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_space && load) begin
      res_r <= res;
    end
  end

endmodule

### sv/lsb_stego_extractor.sv
// Top level: 24-bit BMP LSB payload extractor
// A carrier byte transaction is held in the input register; its result is then
//   held in the result register.
// Throughput: one carrier byte per cycle except while a result waits for space.
// Reset (rst_n low, synchronous): header phase, counters cleared, lsb_mode 0,
//   plain_payload 1, length limit 0, both channel registers empty.
module lsb_stego_extractor
  import lsx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_carrier_byte,
  input  logic        in_start_of_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_payload_byte,
  output logic        out_is_extension,
  output logic        out_last,
  output logic [2:0]  out_status,
  output logic [4:0]  out_header_faults,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  cfg_t       cfg_r;
  logic       go;
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_sof;
  logic       res_valid;
  res_t       res;
  logic       out_space;
  res_t       out_res;

  // the length bound is kept precomputed from the file size
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lsb_mode      <= MODE_LSB1;
      cfg_r.plain_payload <= 1'b1;
      cfg_r.len_limit     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LSB_MODE:  cfg_r.lsb_mode      <= cfg_wdata[1:0];
        REG_PLAIN:     cfg_r.plain_payload <= cfg_wdata[0];
        REG_FILE_SIZE: cfg_r.len_limit     <= (cfg_wdata > LEN_OVERHEAD) ?
                                              cfg_wdata - LEN_OVERHEAD : '0;
        default:       cfg_r <= cfg_r;
      endcase
    end
  end

  lsx_in_stage u_in (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_carrier_byte  (in_carrier_byte),
    .in_start_of_file (in_start_of_file),
    .go               (go),
    .s1_valid         (s1_valid),
    .s1_byte          (s1_byte),
    .s1_sof           (s1_sof)
  );

  lsx_extract u_ext (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .s1_valid  (s1_valid),
    .s1_byte   (s1_byte),
    .s1_sof    (s1_sof),
    .out_space (out_space),
    .go        (go),
    .res_valid (res_valid),
    .res       (res)
  );

  lsx_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (go && res_valid),
    .res       (res),
    .out_ready (out_ready),
    .out_space (out_space),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_payload_byte  = out_res.payload_byte;
  assign out_is_extension  = out_res.is_extension;
  assign out_last          = out_res.last;
  assign out_status        = out_res.status;
  assign out_header_faults = out_res.header_faults;

endmodule

### sv/lsx_checker.sv
// Port-level checker for the extractor, bound to the top level
`include "assert_macros.svh"

module lsx_port_props
  import lsx_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_payload_byte,
  input logic       out_is_extension,
  input logic       out_last,
  input logic [2:0] out_status,
  input logic [4:0] out_header_faults
);

  logic        held;
  logic [17:0] res_bits;
  logic        st_rej;
  logic        st_other;
  logic        st_info;
  logic        no_data;
  logic        st_len_err;

  assign held       = out_valid && !out_ready;
  assign res_bits   = {out_payload_byte, out_is_extension, out_last, out_status,
                       out_header_faults};
  assign st_rej     = out_valid && out_status == ST_HDR_BAD;
  assign st_other   = out_valid && out_status != ST_HDR_BAD;
  assign st_info    = out_valid && out_status != ST_BYTE;
  assign no_data    = out_payload_byte == 8'd0 && !out_is_extension;
  assign st_len_err = out_valid && (out_status == ST_TOO_LARGE || out_status == ST_LEN_ZERO);

  `LSX_ASSERT_NEXT(a_out_hold, clk, rst_n, held, out_valid && $stable(res_bits))
  `LSX_ASSERT_NOW(a_rej_faults, clk, rst_n, st_rej, out_last && out_header_faults != 5'd0)
  `LSX_ASSERT_NOW(a_faults_only_rej, clk, rst_n, st_other, out_header_faults == 5'd0)
  `LSX_ASSERT_NOW(a_status_no_data, clk, rst_n, st_info, no_data)
  `LSX_ASSERT_NOW(a_err_last, clk, rst_n, st_len_err, out_last)

endmodule

bind lsb_stego_extractor lsx_port_props u_lsx_port_props (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_payload_byte  (out_payload_byte),
  .out_is_extension  (out_is_extension),
  .out_last          (out_last),
  .out_status        (out_status),
  .out_header_faults (out_header_faults)
);
